/* sv/record_batch_framer_core_macros.svh */
// ----------------------------------------------------------------------------
// Record batch framer assertion macros
// Shorthand for the clocked assertions of the framer, sampled on clk and
// switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RECORD_BATCH_FRAMER_CORE_MACROS_SVH
`define RECORD_BATCH_FRAMER_CORE_MACROS_SVH

// A condition that holds at every clock edge.
`define RBF_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that holds in the same cycle as its antecedent.
`define RBF_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that holds in the cycle after its antecedent.
`define RBF_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rbf_pkg.sv */
// ----------------------------------------------------------------------------
// Record batch framer package
// Shared constants, codes and types of the framer core.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int BUFFER_BYTES_DEF = 512;
  localparam int MAX_CAP          = 512;
  localparam int HDR_LEN          = 4;
  localparam int CMP_W            = 10;
  localparam int PADDR_W          = 4;

  localparam logic [7:0] HDR_BYTE = 8'h5A;

  localparam logic [8:0]  MAX_FILL_RST       = 9'd256;
  localparam logic [7:0]  RECORD_LIMIT_RST   = 8'd200;
  localparam logic [15:0] FLUSH_PERIOD_RST   = 16'd200;
  localparam logic [31:0] FIRST_DEADLINE_RST = 32'd1000;

  // Input item kinds; the fourth code is ignored.
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_OPEN   = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_MAX_FILL       = 2'd0;
  localparam logic [1:0] REG_RECORD_LIMIT   = 2'd1;
  localparam logic [1:0] REG_FLUSH_PERIOD   = 2'd2;
  localparam logic [1:0] REG_FIRST_DEADLINE = 2'd3;

  typedef struct packed {
    logic [8:0]  max_fill;
    logic [7:0]  record_limit;
    logic [15:0] flush_period;
    logic [31:0] first_deadline;
    logic        fd_wr;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

/* sv/rbf_regs.sv */
// ----------------------------------------------------------------------------
// Record batch framer configuration registers
// APB-style register file holding the fill bound, record limit, flush period
// and first deadline, with a strobe on each first deadline write.
// ----------------------------------------------------------------------------
module rbf_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbf_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output rbf_pkg::cfg_t                cfg
);
  import rbf_pkg::*;

  logic [8:0]  max_fill_r,       max_fill_nxt;
  logic [7:0]  record_limit_r,   record_limit_nxt;
  logic [15:0] flush_period_r,   flush_period_nxt;
  logic [31:0] first_deadline_r, first_deadline_nxt;
  logic        wr_en;
  logic        fd_wr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    max_fill_nxt       = max_fill_r;
    record_limit_nxt   = record_limit_r;
    flush_period_nxt   = flush_period_r;
    first_deadline_nxt = first_deadline_r;
    fd_wr              = 1'b0;
    prdata             = '0;
    unique case (paddr[3:2])
      REG_MAX_FILL: begin
        prdata = {23'd0, max_fill_r};
        if (wr_en) max_fill_nxt = pwdata[8:0];
      end
      REG_RECORD_LIMIT: begin
        prdata = {24'd0, record_limit_r};
        if (wr_en) record_limit_nxt = pwdata[7:0];
      end
      REG_FLUSH_PERIOD: begin
        prdata = {16'd0, flush_period_r};
        if (wr_en) flush_period_nxt = pwdata[15:0];
      end
      REG_FIRST_DEADLINE: begin
        prdata = first_deadline_r;
        if (wr_en) begin
          first_deadline_nxt = pwdata;
          fd_wr              = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fill_r       <= MAX_FILL_RST;
      record_limit_r   <= RECORD_LIMIT_RST;
      flush_period_r   <= FLUSH_PERIOD_RST;
      first_deadline_r <= FIRST_DEADLINE_RST;
    end else begin
      max_fill_r       <= max_fill_nxt;
      record_limit_r   <= record_limit_nxt;
      flush_period_r   <= flush_period_nxt;
      first_deadline_r <= first_deadline_nxt;
    end
  end

  assign cfg.max_fill       = max_fill_r;
  assign cfg.record_limit   = record_limit_r;
  assign cfg.flush_period   = flush_period_r;
  // The value being written travels with the strobe, so the core can load
  // its deadline at the same edge as the register.
  assign cfg.first_deadline = first_deadline_nxt;
  assign cfg.fd_wr          = fd_wr;

endmodule

/* sv/rbf_store.sv */
// ----------------------------------------------------------------------------
// Record batch framer frame store
// Synchronous frame buffer, eight bytes to a row: byte-lane writes from the
// packing side, whole-row reads with registered data for the drain.
// ----------------------------------------------------------------------------
module rbf_store #(
  parameter int CAP = rbf_pkg::MAX_CAP
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(CAP)-1:0]      wr_addr,
  input  logic [7:0]                  wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(CAP)-4:0]      rd_addr,
  output logic [63:0]                 rd_data
);
  import rbf_pkg::*;

  localparam int AW    = $clog2(CAP);
  localparam int WAW   = AW - 3;
  localparam int WORDS = (CAP + 7) / 8;

  logic [63:0] mem_r [WORDS];
  logic [63:0] rd_data_r;

  // Byte position p lives in row p/8, lane p%8, so a row is a frame word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[AW-1:3]][{wr_addr[2:0], 3'b000} +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr[WAW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/record_batch_framer_core.sv */
// ----------------------------------------------------------------------------
// Record batch framer core
// Packs record bytes into frames (header 0x5A, record count, 16-bit length,
// payload, 8-bit checksum) and sends each frame as 8-byte words.
//
//   Channel   Direction  Ports                     Moves
//   in_       in         in_valid / in_ready       one record byte or command
//   out_      out        out_valid / out_ready     one frame word, up to 8 bytes
//   config    in         psel/penable/pwrite/...   one 32-bit register write
//
// A record byte that causes no flush, an open item and an ignored item are
// taken one per cycle. A flush or finish holds off input while the frame is
// drained one frame word at a time through the single store read port.
// A stalled output word holds the drain until the word is taken.
// Reset is synchronous; the frame store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "record_batch_framer_core_macros.svh"

module record_batch_framer_core #(
  parameter int BUFFER_BYTES = rbf_pkg::BUFFER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_first_of_record,
  input  logic [7:0]                   in_record_length,
  input  logic [31:0]                  in_now_time,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [63:0]                  out_frame_word,
  output logic [3:0]                   out_byte_count,
  output logic                         out_last_of_frame,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbf_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rbf_pkg::*;

  localparam int CAP = (BUFFER_BYTES < MAX_CAP) ? BUFFER_BYTES : MAX_CAP;
  localparam int AW  = $clog2(CAP);
  localparam int WAW = AW - 3;

  localparam logic [AW-1:0]    HDR_FILL = AW'(HDR_LEN);
  localparam logic [AW-1:0]    FILL_TOP = AW'(CAP - 1);
  localparam logic [CMP_W-1:0] CAP_BND  = CMP_W'(CAP - 1);

  cfg_t cfg;

  // control state
  state_t         state_r,    state_nxt;
  logic [AW-1:0]  fill_r,     fill_nxt;
  logic [7:0]     rc_r,       rc_nxt;
  logic [7:0]     sum_r,      sum_nxt;
  logic [31:0]    deadline_r, deadline_nxt;
  logic           open_r,     open_nxt;
  logic           noflush_r,  noflush_nxt;
  logic           pend_r,     pend_nxt;
  logic           out_valid_r, out_valid_nxt;

  // drain snapshot and output payload
  logic [AW-1:0]  dfill_r,     dfill_nxt;
  logic [7:0]     drc_r,       drc_nxt;
  logic [7:0]     dsum_r,      dsum_nxt;
  logic [WAW-1:0] idx_r,       idx_nxt;
  logic [7:0]     pend_data_r, pend_data_nxt;
  logic [63:0]    out_word_r,  out_word_nxt;
  logic [3:0]     out_cnt_r,   out_cnt_nxt;
  logic           out_last_r,  out_last_nxt;

  // store port
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [WAW-1:0] rd_addr;
  logic [63:0]    rd_data;

  logic             in_accept;
  logic             slot_free;
  logic [CMP_W-1:0] plen;
  logic [CMP_W-1:0] dplen;
  logic [7:0]       chk;
  logic [CMP_W-1:0] bound;
  logic [CMP_W-1:0] need;
  logic             flush_rec;
  logic [WAW-1:0]   dlast;
  logic [63:0]      fmt_word;
  logic [3:0]       fmt_cnt;

  rbf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbf_store #(.CAP(CAP)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Checksum of the pending frame: payload sum plus the four header bytes.
  assign plen  = CMP_W'(fill_r) - CMP_W'(HDR_LEN);
  assign chk   = sum_r + HDR_BYTE + rc_r + plen[7:0] + {6'd0, plen[9:8]};
  assign bound = (CMP_W'(cfg.max_fill) < CAP_BND) ? CMP_W'(cfg.max_fill) : CAP_BND;
  assign need  = CMP_W'(fill_r) + CMP_W'(in_record_length);

  assign flush_rec = in_first_of_record &&
                     ((rc_r >= cfg.record_limit) || (in_now_time > deadline_r) ||
                      (need >= bound));

  assign dlast = dfill_r[AW-1:3];
  assign dplen = CMP_W'(dfill_r) - CMP_W'(HDR_LEN);

  // Overlay the header and checksum on the stored row; bytes past the
  // checksum are zero.
  always_comb begin
    logic [AW-1:0] pos;
    logic [7:0]    lane;
    fmt_word = '0;
    for (int k = 0; k < 8; k++) begin
      pos  = {idx_r, 3'(k)};
      lane = rd_data[8*k +: 8];
      if (pos == AW'(0))       fmt_word[8*k +: 8] = HDR_BYTE;
      else if (pos == AW'(1))  fmt_word[8*k +: 8] = drc_r;
      else if (pos == AW'(2))  fmt_word[8*k +: 8] = dplen[7:0];
      else if (pos == AW'(3))  fmt_word[8*k +: 8] = {6'd0, dplen[9:8]};
      else if (pos < dfill_r)  fmt_word[8*k +: 8] = lane;
      else if (pos == dfill_r) fmt_word[8*k +: 8] = dsum_r;
      else                     fmt_word[8*k +: 8] = 8'd0;
    end
    fmt_cnt = (idx_r == dlast) ? (4'({1'b0, dfill_r[2:0]}) + 4'd1) : 4'd8;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rc_nxt        = rc_r;
    sum_nxt       = sum_r;
    deadline_nxt  = deadline_r;
    open_nxt      = open_r;
    noflush_nxt   = noflush_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dfill_nxt     = dfill_r;
    drc_nxt       = drc_r;
    dsum_nxt      = dsum_r;
    idx_nxt       = idx_r;
    pend_data_nxt = pend_data_r;
    out_word_nxt  = out_word_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = fill_r;
    wr_data       = in_data_byte;
    rd_en         = 1'b0;
    rd_addr       = '0;

    // Before the first flush the deadline follows the register.
    if (cfg.fd_wr && noflush_r) deadline_nxt = cfg.first_deadline;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_kind)
            KIND_OPEN: begin
              open_nxt = 1'b1;
              fill_nxt = HDR_FILL;
              sum_nxt  = 8'd0;
            end
            KIND_FINISH: begin
              if (open_r) begin
                dfill_nxt   = fill_r;
                drc_nxt     = rc_r;
                dsum_nxt    = chk;
                idx_nxt     = '0;
                rd_en       = 1'b1;
                state_nxt   = ST_DRAIN;
                noflush_nxt = 1'b0;
                open_nxt    = 1'b0;
                fill_nxt    = HDR_FILL;
                rc_nxt      = 8'd0;
                sum_nxt     = 8'd0;
              end
            end
            KIND_BYTE: begin
              if (open_r) begin
                if (flush_rec) begin
                  dfill_nxt     = fill_r;
                  drc_nxt       = rc_r;
                  dsum_nxt      = chk;
                  idx_nxt       = '0;
                  rd_en         = 1'b1;
                  state_nxt     = ST_DRAIN;
                  noflush_nxt   = 1'b0;
                  deadline_nxt  = in_now_time + 32'(cfg.flush_period);
                  // The byte opens the new frame; it is written once the old
                  // frame has been read out.
                  pend_nxt      = 1'b1;
                  pend_data_nxt = in_data_byte;
                  fill_nxt      = HDR_FILL + AW'(1);
                  rc_nxt        = 8'd1;
                  sum_nxt       = in_data_byte;
                end else begin
                  if (in_first_of_record) rc_nxt = rc_r + 8'd1;
                  if (fill_r < FILL_TOP) begin
                    wr_en    = 1'b1;
                    fill_nxt = fill_r + AW'(1);
                    sum_nxt  = sum_r + in_data_byte;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = fmt_word;
          out_cnt_nxt   = fmt_cnt;
          out_last_nxt  = (idx_r == dlast);
          if (idx_r == dlast) begin
            state_nxt = ST_IDLE;
            pend_nxt  = 1'b0;
            if (pend_r) begin
              wr_en   = 1'b1;
              wr_addr = HDR_FILL;
              wr_data = pend_data_r;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + WAW'(1);
            idx_nxt = idx_r + WAW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= HDR_FILL;
      rc_r        <= 8'd0;
      sum_r       <= 8'd0;
      deadline_r  <= FIRST_DEADLINE_RST;
      open_r      <= 1'b1;
      noflush_r   <= 1'b1;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rc_r        <= rc_nxt;
      sum_r       <= sum_nxt;
      deadline_r  <= deadline_nxt;
      open_r      <= open_nxt;
      noflush_r   <= noflush_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dfill_r     <= dfill_nxt;
    drc_r       <= drc_nxt;
    dsum_r      <= dsum_nxt;
    idx_r       <= idx_nxt;
    pend_data_r <= pend_data_nxt;
    out_word_r  <= out_word_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_frame_word    = out_word_r;
  assign out_byte_count    = out_cnt_r;
  assign out_last_of_frame = out_last_r;

  `RBF_ALWAYS(a_fill_range, (fill_r >= HDR_FILL) && (fill_r <= FILL_TOP),
    "fill count left the header-to-capacity range")
  `RBF_ALWAYS(a_port_clash, !(rd_en && wr_en), "store read and write in one cycle")
  `RBF_IMPLIES(a_idx_bound, state_r == ST_DRAIN, idx_r <= dlast,
    "drain read past the checksum word")
  `RBF_NEXT(a_finish_drain, in_accept && (in_kind == KIND_FINISH) && open_r,
    state_r == ST_DRAIN, "finish item did not start a drain")
  `RBF_IMPLIES(a_pend_drain, pend_r, state_r == ST_DRAIN,
    "held record byte outside a drain")

endmodule
